// ===== rtl/core/cnt_pkg.sv =====
// ----------------------------------------------------------------------------
// cnt_pkg
// Types and constants shared by the conditional nesting tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cnt_pkg;

    // deepest nesting level the stack holds
    localparam int MAX_NEST = 32;

    localparam int LVL_W   = $clog2(MAX_NEST + 1);
    localparam int IDX_W   = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam int DEPTH_W = 6;

    typedef enum logic [2:0] {
        MODE_IF     = 3'd0,
        MODE_IFDEF  = 3'd1,
        MODE_IFNDEF = 3'd2,
        MODE_ELIF   = 3'd3,
        MODE_ELSE   = 3'd4,
        MODE_ENDIF  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        BR_TRUE  = 2'd0,
        BR_FALSE = 2'd1,
        BR_NEVER = 2'd2
    } t_br;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_ELSE_TWICE = 3'd1,
        ERR_ELIF_OUT   = 3'd2,
        ERR_ELSE_OUT   = 3'd3,
        ERR_ENDIF_OUT  = 3'd4,
        ERR_OVERFLOW   = 3'd5
    } t_err;

    typedef struct packed {
        logic [2:0] mode;
        logic       cond_true;
        logic       name_present;
    } t_item;

    // one stack level: else-seen flag and branch state
    typedef struct packed {
        logic els;
        t_br  st;
    } t_ent;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        t_br              cur;
        logic             top_else;
    } t_state;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_ent             ent;
    } t_wr;

    typedef struct packed {
        logic               emit_active;
        t_br                branch_state;
        logic [DEPTH_W-1:0] nest_depth;
        t_err               error_code;
        logic               bad_symbol;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/core/cnt_step.sv =====
// ----------------------------------------------------------------------------
// cnt_step
// Next-state and result logic for one directive against the stack top.
// ----------------------------------------------------------------------------
`default_nettype none

module cnt_step
    import cnt_pkg::*;
(
    input  wire t_item  i_item,
    input  wire t_state i_state,
    input  wire t_ent   i_below,     // entry one level under the top
    output t_state      o_state,
    output t_wr         o_wr,
    output t_res        o_res
);

    t_br              w_open_st;
    t_br              w_alt_st;
    logic             w_full;
    logic             w_bad;
    t_err             w_err;
    logic             w_push;
    logic             w_upd;
    t_state           w_nxt;

    always_comb begin
        w_full    = (i_state.level >= LVL_W'(MAX_NEST));
        w_bad     = 1'b0;
        w_open_st = BR_NEVER;
        if (i_state.cur == BR_TRUE) begin
            if (t_mode'(i_item.mode) == MODE_IF) begin
                w_open_st = i_item.cond_true ? BR_TRUE : BR_FALSE;
            end else if (!i_item.name_present) begin
                w_open_st = BR_FALSE;
                w_bad     = 1'b1;
            end else if ((t_mode'(i_item.mode) == MODE_IFDEF) == i_item.cond_true) begin
                w_open_st = BR_TRUE;
            end else begin
                w_open_st = BR_FALSE;
            end
        end

        // elif/else: a taken branch closes, a pending one may open
        case (i_state.cur)
            BR_TRUE:  w_alt_st = BR_NEVER;
            BR_FALSE: w_alt_st = (t_mode'(i_item.mode) == MODE_ELSE || i_item.cond_true)
                                 ? BR_TRUE : BR_FALSE;
            default:  w_alt_st = i_state.cur;
        endcase
    end

    always_comb begin
        w_nxt  = i_state;
        w_err  = ERR_NONE;
        w_push = 1'b0;
        w_upd  = 1'b0;
        unique case (t_mode'(i_item.mode)) inside
            MODE_IF, MODE_IFDEF, MODE_IFNDEF: begin
                if (w_full) begin
                    w_err = ERR_OVERFLOW;
                end else begin
                    w_push         = 1'b1;
                    w_nxt.level    = i_state.level + LVL_W'(1);
                    w_nxt.cur      = w_open_st;
                    w_nxt.top_else = 1'b0;
                end
            end
            MODE_ELIF, MODE_ELSE: begin
                if (i_state.level == '0) begin
                    w_err = (t_mode'(i_item.mode) == MODE_ELIF) ? ERR_ELIF_OUT : ERR_ELSE_OUT;
                end else if (i_state.top_else) begin
                    w_err = ERR_ELSE_TWICE;
                end else begin
                    w_upd          = 1'b1;
                    w_nxt.cur      = w_alt_st;
                    w_nxt.top_else = (t_mode'(i_item.mode) == MODE_ELSE);
                end
            end
            MODE_ENDIF: begin
                if (i_state.level == '0) begin
                    w_err = ERR_ENDIF_OUT;
                end else begin
                    w_nxt.level    = i_state.level - LVL_W'(1);
                    w_nxt.cur      = i_below.st;
                    w_nxt.top_else = i_below.els;
                end
            end
            default: ;
        endcase
    end

    assign o_state    = w_nxt;
    assign o_wr.en    = w_push || w_upd;
    assign o_wr.idx   = IDX_W'(w_nxt.level - LVL_W'(1));
    assign o_wr.ent   = '{els: w_nxt.top_else, st: w_nxt.cur};

    assign o_res.emit_active  = (w_nxt.cur == BR_TRUE);
    assign o_res.branch_state = w_nxt.cur;
    assign o_res.nest_depth   = DEPTH_W'(w_nxt.level);
    assign o_res.error_code   = w_err;
    // the missing-identifier flag stands even when the push overflows
    assign o_res.bad_symbol   = w_bad &&
                                (t_mode'(i_item.mode) == MODE_IFDEF ||
                                 t_mode'(i_item.mode) == MODE_IFNDEF);

endmodule

`default_nettype wire

// ===== rtl/core/conditional_nesting_tracker.sv =====
// ----------------------------------------------------------------------------
// conditional_nesting_tracker
// Follows nested conditional-compilation directives and reports branch
// state, nesting depth and errors for each one.
// ----------------------------------------------------------------------------
//  channel  dir  tdata bits (low first)                            tuser/tlast
//  s        in   mode[2:0] cond_true[3] name_present[4] (8 bits)   none
//  m        out  emit_active[0] branch_state[2:1] nest_depth[8:3]  none
//                error_code[11:9] bad_symbol[12] (16 bits)
//
//  One directive per cycle sustained while the result side accepts; each
//  result passes through the input register, then the result register.
//  The stack top lives in registers, so each step is one push, pop or top
//  update; lower levels sit in a 32-entry register stack read at one index.
//  Reset clears depth and the input and result valid flags; the stack
//  contents need no clearing. A stalled result stalls the input once the
//  input register holds a directive.
// ----------------------------------------------------------------------------
`default_nettype none

module conditional_nesting_tracker
    import cnt_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // mode[2:0], cond_true[3], name_present[4]
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata    // emit_active[0], branch_state[2:1],
                                     // nest_depth[8:3], error_code[11:9],
                                     // bad_symbol[12]
);

    logic             r_in_valid;
    t_item            r_in;
    logic             r_out_valid;
    t_res             r_out;
    t_state           r_state;
    t_ent             r_stk [MAX_NEST];

    logic             w_out_free;
    logic             w_proc;
    t_ent             w_below;
    t_state           n_state;
    t_wr              w_wr;
    t_res             n_out;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_proc     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;

    // level 0 has a fixed true state
    always_comb begin
        if (r_state.level <= LVL_W'(1)) begin
            w_below = '{els: 1'b0, st: BR_TRUE};
        end else begin
            w_below = r_stk[IDX_W'(r_state.level - LVL_W'(2))];
        end
    end

    cnt_step u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .i_below (w_below),
        .o_state (n_state),
        .o_wr    (w_wr),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{level: '0, cur: BR_TRUE, top_else: 1'b0};
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_proc) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.mode         <= i_s_tdata[2:0];
            r_in.cond_true    <= i_s_tdata[3];
            r_in.name_present <= i_s_tdata[4];
        end
        if (w_proc) begin
            r_out <= n_out;
        end
        if (w_proc && w_wr.en) begin
            r_stk[w_wr.idx] <= w_wr.ent;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.bad_symbol, r_out.error_code, r_out.nest_depth,
                         r_out.branch_state, r_out.emit_active};

    // overflow is only reported with the stack full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.error_code == ERR_OVERFLOW)
        |-> (r_out.nest_depth == DEPTH_W'(MAX_NEST)))
        else $error("overflow reported below full depth");

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.level <= LVL_W'(MAX_NEST))
        else $error("nesting level beyond stack depth");

    a_endif_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && t_mode'(r_in.mode) == MODE_ENDIF && r_state.level != '0)
        |=> (r_state.level == $past(r_state.level) - LVL_W'(1)))
        else $error("endif did not pop one level");

    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && n_out.error_code != ERR_NONE) |=> $stable(r_state))
        else $error("stack changed on a failed directive");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directive streams into the conditional nesting tracker and checks
// each status transfer against a cycle-free model of the branch stack. A
// short directed table covers the error codes, bad symbols and overflow.
// Random episodes follow: mostly well-formed nests of varying depth, a few
// reaching the stack limit, with random noise mixed in. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import cnt_pkg::*;

    localparam int          RAND_ITEMS  = 1010;
    localparam int          STALL_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 80;
    localparam logic [2:0]  MODE_SPARE_A = 3'd6;
    localparam logic [2:0]  MODE_SPARE_B = 3'd7;
    localparam t_res        NO_RES = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // mode[2:0], cond_true[3], name_present[4]
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;    // emit_active[0], branch_state[2:1], nest_depth[8:3],
                               // error_code[11:9], bad_symbol[12]

    conditional_nesting_tracker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // shadow of the branch stack
    int   lvl;
    t_br  cur;
    t_br  saved_st  [0:MAX_NEST];
    bit   saved_els [0:MAX_NEST];
    int   aim_depth;

    t_res status_q [$];
    int   mismatches;
    bit   no_idle;
    bit   stall_req;

    function automatic t_res track_directive(logic [2:0] mode, bit cond, bit named);
        t_res r;
        t_br  nxt;
        t_err err;
        bit   bad;
        bit   opening;
        err     = ERR_NONE;
        bad     = 1'b0;
        opening = 1'b0;
        nxt     = BR_NEVER;
        case (mode)
            MODE_IF: begin
                nxt     = (cur == BR_TRUE) ? (cond ? BR_TRUE : BR_FALSE) : BR_NEVER;
                opening = 1'b1;
            end
            MODE_IFDEF, MODE_IFNDEF: begin
                if (cur == BR_TRUE) begin
                    if (named) begin
                        nxt = (((mode == MODE_IFDEF) ? cond : !cond)) ? BR_TRUE : BR_FALSE;
                    end else begin
                        nxt = BR_FALSE;
                        bad = 1'b1;
                    end
                end
                opening = 1'b1;
            end
            MODE_ELIF, MODE_ELSE: begin
                if (lvl == 0) begin
                    err = (mode == MODE_ELIF) ? ERR_ELIF_OUT : ERR_ELSE_OUT;
                end else if (saved_els[lvl]) begin
                    err = ERR_ELSE_TWICE;
                end else begin
                    if (cur == BR_TRUE)
                        nxt = BR_NEVER;
                    else if (cur == BR_FALSE)
                        nxt = (mode == MODE_ELIF) ? (cond ? BR_TRUE : BR_FALSE) : BR_TRUE;
                    else
                        nxt = cur;
                    cur            = nxt;
                    saved_st[lvl]  = nxt;
                    saved_els[lvl] = (mode == MODE_ELSE);
                end
            end
            MODE_ENDIF: begin
                if (lvl == 0) begin
                    err = ERR_ENDIF_OUT;
                end else begin
                    lvl--;
                    cur = saved_st[lvl];
                end
            end
            default: ;
        endcase
        // stack full: the open is refused and nothing moves
        if (opening) begin
            if (lvl >= MAX_NEST) begin
                err = ERR_OVERFLOW;
            end else begin
                lvl++;
                saved_st[lvl]  = nxt;
                saved_els[lvl] = 1'b0;
                cur            = nxt;
            end
        end
        r.emit_active  = (cur == BR_TRUE);
        r.branch_state = cur;
        r.nest_depth   = lvl[DEPTH_W-1:0];
        r.error_code   = err;
        r.bad_symbol   = bad;
        return r;
    endfunction

    task automatic offer_directive(input logic [2:0] mode, input bit cond, input bit named,
                                   input bit fixed, input t_res fixed_res);
        t_res exp_r;
        while (!no_idle && $urandom_range(99) < 31) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {3'b000, named, cond, mode};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        exp_r = track_directive(mode, cond, named);
        status_q.push_back(fixed ? fixed_res : exp_r);
    endtask

    // deep episodes run to the stack limit, then drain
    task automatic pick_directive(output logic [2:0] mode, output bit cond, output bit named);
        cond  = 1'($urandom_range(1));
        named = ($urandom_range(9) != 0);
        if (lvl == 0)
            aim_depth = ($urandom_range(11) == 0) ? MAX_NEST + 1 : int'($urandom_range(6, 1));
        if (lvl >= MAX_NEST && $urandom_range(3) == 0)
            aim_depth = 0;
        if ($urandom_range(99) < 8) begin
            mode  = 3'($urandom_range(7));
            named = 1'($urandom_range(1));
        end else if (lvl == 0 || (lvl < aim_depth && $urandom_range(2) != 0)) begin
            mode = 3'($urandom_range(2));
        end else if (!saved_els[lvl] && $urandom_range(1) != 0) begin
            mode = ($urandom_range(1) != 0) ? MODE_ELIF : MODE_ELSE;
        end else begin
            mode = MODE_ENDIF;
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
    endtask

    typedef struct packed {
        logic [2:0] mode;
        logic       cond;
        logic       named;
        logic [5:0] reps;
        logic       fixed;
        t_res       want;
    } t_dir_row;

    localparam int DIR_ROWS = 25;
    t_dir_row dir_tab [0:DIR_ROWS-1] = '{
        '{MODE_ENDIF,   1'b0, 1'b0, 6'd1,  1'b1, '{1'b1, BR_TRUE, 6'd0, ERR_ENDIF_OUT, 1'b0}},
        '{MODE_ELIF,    1'b1, 1'b1, 6'd1,  1'b1, '{1'b1, BR_TRUE, 6'd0, ERR_ELIF_OUT, 1'b0}},
        '{MODE_ELSE,    1'b0, 1'b1, 6'd1,  1'b1, '{1'b1, BR_TRUE, 6'd0, ERR_ELSE_OUT, 1'b0}},
        '{MODE_SPARE_A, 1'b1, 1'b1, 6'd1,  1'b1, '{1'b1, BR_TRUE, 6'd0, ERR_NONE, 1'b0}},
        '{MODE_SPARE_B, 1'b0, 1'b0, 6'd1,  1'b1, '{1'b1, BR_TRUE, 6'd0, ERR_NONE, 1'b0}},
        '{MODE_IF,      1'b1, 1'b1, 6'd1,  1'b0, NO_RES},
        // missing identifier in a live branch
        '{MODE_IFDEF,   1'b0, 1'b0, 6'd1,  1'b1, '{1'b0, BR_FALSE, 6'd2, ERR_NONE, 1'b1}},
        '{MODE_ELIF,    1'b0, 1'b1, 6'd1,  1'b0, NO_RES},
        '{MODE_ELIF,    1'b1, 1'b1, 6'd1,  1'b0, NO_RES},
        '{MODE_IF,      1'b0, 1'b1, 6'd1,  1'b0, NO_RES},
        // dead branch: no identifier check
        '{MODE_IFNDEF,  1'b1, 1'b0, 6'd1,  1'b0, NO_RES},
        '{MODE_ELSE,    1'b1, 1'b1, 6'd1,  1'b0, NO_RES},
        '{MODE_ELSE,    1'b0, 1'b1, 6'd1,  1'b1, '{1'b0, BR_NEVER, 6'd4, ERR_ELSE_TWICE, 1'b0}},
        '{MODE_ELIF,    1'b1, 1'b1, 6'd1,  1'b1, '{1'b0, BR_NEVER, 6'd4, ERR_ELSE_TWICE, 1'b0}},
        '{MODE_ENDIF,   1'b0, 1'b1, 6'd1,  1'b0, NO_RES},
        '{MODE_ELSE,    1'b0, 1'b1, 6'd1,  1'b0, NO_RES},
        '{MODE_ENDIF,   1'b1, 1'b0, 6'd3,  1'b0, NO_RES},
        '{MODE_IFDEF,   1'b1, 1'b1, 6'd1,  1'b0, NO_RES},
        '{MODE_IFNDEF,  1'b1, 1'b1, 6'd1,  1'b0, NO_RES},
        '{MODE_ENDIF,   1'b0, 1'b0, 6'd2,  1'b0, NO_RES},
        // fill the stack, then try to open past it
        '{MODE_IF,      1'b1, 1'b1, 6'd32, 1'b0, NO_RES},
        '{MODE_IFDEF,   1'b0, 1'b0, 6'd1,  1'b1, '{1'b1, BR_TRUE, 6'd32, ERR_OVERFLOW, 1'b1}},
        '{MODE_IF,      1'b1, 1'b1, 6'd1,  1'b1, '{1'b1, BR_TRUE, 6'd32, ERR_OVERFLOW, 1'b0}},
        '{MODE_IFNDEF,  1'b0, 1'b1, 6'd1,  1'b1, '{1'b1, BR_TRUE, 6'd32, ERR_OVERFLOW, 1'b0}},
        '{MODE_ENDIF,   1'b0, 1'b0, 6'd32, 1'b0, NO_RES}
    };

    initial begin : stimulus
        logic [2:0] mode;
        bit         cond;
        bit         named;
        lvl        = 0;
        cur        = BR_TRUE;
        aim_depth  = 0;
        mismatches = 0;
        no_idle    = 1'b0;
        stall_req  = 1'b0;
        for (int k = 0; k <= MAX_NEST; k++) begin
            saved_st[k]  = BR_TRUE;
            saved_els[k] = 1'b0;
        end
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[r]) begin
            for (int k = 0; k < dir_tab[r].reps; k++)
                offer_directive(dir_tab[r].mode, dir_tab[r].cond, dir_tab[r].named,
                                dir_tab[r].fixed, dir_tab[r].want);
        end
        wait_drained();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 300)
                stall_req = 1'b1;
            if (n == 600)
                wait_drained();
            no_idle = (n >= 800 && n < 1000);
            pick_directive(mode, cond, named);
            offer_directive(mode, cond, named, 1'b0, NO_RES);
        end
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && status_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : result_side
        t_res got;
        t_res want;
        int   hold;
        hold = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_m_tvalid === 1'b1 && i_m_tready === 1'b1) begin
                got.emit_active  = o_m_tdata[0];
                got.branch_state = t_br'(o_m_tdata[2:1]);
                got.nest_depth   = o_m_tdata[8:3];
                got.error_code   = t_err'(o_m_tdata[11:9]);
                got.bad_symbol   = o_m_tdata[12];
                if (status_q.size() == 0) begin
                    $error("status transfer with nothing pending: tdata %h", o_m_tdata);
                    mismatches++;
                end else begin
                    want = status_q.pop_front();
                    if (got.emit_active !== want.emit_active) begin
                        $error("emit_active: expected %0d, got %0d",
                               want.emit_active, got.emit_active);
                        mismatches++;
                    end
                    if (got.branch_state !== want.branch_state) begin
                        $error("branch_state: expected %0d, got %0d",
                               want.branch_state, got.branch_state);
                        mismatches++;
                    end
                    if (got.nest_depth !== want.nest_depth) begin
                        $error("nest_depth: expected %0d, got %0d",
                               want.nest_depth, got.nest_depth);
                        mismatches++;
                    end
                    if (got.error_code !== want.error_code) begin
                        $error("error_code: expected %0d, got %0d",
                               want.error_code, got.error_code);
                        mismatches++;
                    end
                    if (got.bad_symbol !== want.bad_symbol) begin
                        $error("bad_symbol: expected %0d, got %0d",
                               want.bad_symbol, got.bad_symbol);
                        mismatches++;
                    end
                end
            end
            // long hold-off backs the stream up into the input side
            if (stall_req) begin
                hold      = HOLD_CYCLES;
                stall_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_m_tready <= 1'b0;
            end else if (no_idle) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= 31);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid === 1'b1 && o_s_tready === 1'b1) ||
                (o_m_tvalid === 1'b1 && i_m_tready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

endmodule
